### rtl/implode_stream_decompressor_macros.svh
//------------------------------------------------------------------------------
// implode_stream_decompressor_macros
// Assertion macros shared by the decompressor RTL.
//------------------------------------------------------------------------------
`ifndef IMPLODE_STREAM_DECOMPRESSOR_MACROS_SVH
`define IMPLODE_STREAM_DECOMPRESSOR_MACROS_SVH
`ifndef SYNTHESIS
`define ISD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ISD_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISD_ASSERT(lbl, clk, rst, prop, msg)
`define ISD_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### rtl/isd_pkg.sv
//------------------------------------------------------------------------------
// isd_pkg
// Types, constants and code tables of the implode stream decompressor.
//------------------------------------------------------------------------------
package isd_pkg;

   typedef enum logic [3:0] {
      PH_HDR    = 4'd0,
      PH_FLAG   = 4'd1,
      PH_LEN    = 4'd2,
      PH_LENX   = 4'd3,
      PH_LITB   = 4'd4,
      PH_ASTART = 4'd5,
      PH_A4     = 4'd6,
      PH_A6     = 4'd7,
      PH_AFIN   = 4'd8,
      PH_DIST   = 4'd9,
      PH_DLOW   = 4'd10,
      PH_EMIT   = 4'd11,
      PH_COPY   = 4'd12,
      PH_DONE   = 4'd13,
      PH_ERR    = 4'd14
   } phase_type;

   typedef enum logic [2:0] {
      ST_NEED    = 3'd0,
      ST_PEND    = 3'd1,
      ST_DONE    = 3'd2,
      ST_BADDICT = 3'd3,
      ST_BADMODE = 3'd4,
      ST_SHORT   = 3'd5,
      ST_BUSY    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_CONT = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      SQ_IDLE = 2'd0,
      SQ_RUN  = 2'd1,
      SQ_READ = 2'd2,
      SQ_FIN  = 2'd3
   } seq_type;

   localparam logic [9:0] LIT_END  = 10'h305 - 10'h100;
   localparam logic [9:0] LEN_BIAS = 10'hFE - 10'h100;

   function automatic logic [3:0] len_len(input logic [3:0] c);
      case (c)
         4'd0: len_len = 4'd3;  4'd1: len_len = 4'd2;  4'd2: len_len = 4'd3;
         4'd3: len_len = 4'd3;  4'd4: len_len = 4'd4;  4'd5: len_len = 4'd4;
         4'd6: len_len = 4'd4;  4'd7: len_len = 4'd5;  4'd8: len_len = 4'd5;
         4'd9: len_len = 4'd5;  4'd10: len_len = 4'd5; 4'd11: len_len = 4'd6;
         4'd12: len_len = 4'd6; 4'd13: len_len = 4'd6; 4'd14: len_len = 4'd7;
         default: len_len = 4'd7;
      endcase
   endfunction

   function automatic logic [7:0] len_pat(input logic [3:0] c);
      case (c)
         4'd0: len_pat = 8'h05;  4'd1: len_pat = 8'h03;  4'd2: len_pat = 8'h01;
         4'd3: len_pat = 8'h06;  4'd4: len_pat = 8'h0A;  4'd5: len_pat = 8'h02;
         4'd6: len_pat = 8'h0C;  4'd7: len_pat = 8'h14;  4'd8: len_pat = 8'h04;
         4'd9: len_pat = 8'h18;  4'd10: len_pat = 8'h08; 4'd11: len_pat = 8'h30;
         4'd12: len_pat = 8'h10; 4'd13: len_pat = 8'h20; 4'd14: len_pat = 8'h40;
         default: len_pat = 8'h00;
      endcase
   endfunction

   function automatic logic [3:0] len_extra(input logic [3:0] c);
      len_extra = (c < 4'd8) ? 4'd0 : 4'(c - 4'd7);
   endfunction

   function automatic logic [8:0] len_start(input logic [3:0] c);
      case (c)
         4'd9: len_start = 9'h0A;   4'd10: len_start = 9'h0E;
         4'd11: len_start = 9'h16;  4'd12: len_start = 9'h26;
         4'd13: len_start = 9'h46;  4'd14: len_start = 9'h86;
         4'd15: len_start = 9'h106;
         default: len_start = 9'(c);
      endcase
   endfunction

   // prefix match: first code whose pattern matches the low bits
   function automatic logic [3:0] len_lut(input logic [7:0] b);
      logic [3:0] r;
      logic [7:0] m;
      r = 4'd0;
      for (int i = 15; i >= 0; i--) begin
         m = 8'((9'd1 << len_len(4'(i))) - 9'd1);
         if ((b & m) == len_pat(4'(i))) r = 4'(i);
      end
      len_lut = r;
   endfunction

   localparam logic [7:0] DIST_PAT [64] = '{
      8'h03,8'h0D,8'h05,8'h19,8'h09,8'h11,8'h01,8'h3E,8'h1E,8'h2E,8'h0E,8'h36,8'h16,8'h26,
      8'h06,8'h3A,8'h1A,8'h2A,8'h0A,8'h32,8'h12,8'h22,8'h42,8'h02,8'h7C,8'h3C,8'h5C,8'h1C,
      8'h6C,8'h2C,8'h4C,8'h0C,8'h74,8'h34,8'h54,8'h14,8'h64,8'h24,8'h44,8'h04,8'h78,8'h38,
      8'h58,8'h18,8'h68,8'h28,8'h48,8'h08,8'hF0,8'h70,8'hB0,8'h30,8'hD0,8'h50,8'h90,8'h10,
      8'hE0,8'h60,8'hA0,8'h20,8'hC0,8'h40,8'h80,8'h00};

   function automatic logic [3:0] dist_len(input logic [5:0] c);
      if (c == 6'd0) dist_len = 4'd2;
      else if (c < 6'd3) dist_len = 4'd4;
      else if (c < 6'd7) dist_len = 4'd5;
      else if (c < 6'd22) dist_len = 4'd6;
      else if (c < 6'd48) dist_len = 4'd7;
      else dist_len = 4'd8;
   endfunction

   function automatic logic [5:0] dist_lut(input logic [7:0] b);
      logic [5:0] r;
      logic [7:0] m;
      r = 6'd0;
      for (int i = 63; i >= 0; i--) begin
         m = 8'((9'd1 << dist_len(6'(i))) - 9'd1);
         if ((b & m) == DIST_PAT[i]) r = 6'(i);
      end
      dist_lut = r;
   endfunction

   localparam logic [3:0] ASC_LEN [256] = '{
      11,12,12,12,12,12,12,12,12,8,7,12,12,7,12,12, 12,12,12,12,12,12,12,12,12,12,13,12,12,12,12,12,
      4,10,8,12,10,12,10,8,7,7,8,9,7,6,7,8, 7,6,7,7,7,7,8,7,7,8,8,12,11,7,9,11,
      12,6,7,6,6,5,7,8,8,6,11,9,6,7,6,6, 7,11,6,6,6,7,9,8,9,9,11,8,11,9,12,8,
      12,5,6,6,6,5,6,6,6,5,11,7,5,6,5,5, 6,10,5,5,5,5,8,7,8,8,10,11,11,12,12,12,
      13,13,13,13,13,13,13,13,13,13,13,13,13,13,13,13, 13,13,13,13,13,13,13,13,13,13,13,13,13,13,13,13,
      13,13,13,13,13,13,13,13,13,13,13,13,13,13,13,13, 12,12,12,12,12,12,12,12,12,12,12,12,12,12,12,12,
      12,12,12,12,12,12,12,12,12,12,12,12,12,12,12,12, 12,12,12,12,12,12,12,12,12,12,12,12,12,12,12,12,
      13,12,13,13,13,12,13,13,13,12,13,13,13,13,12,13, 13,13,12,12,12,13,13,13,13,13,13,13,13,13,13,13};

   localparam logic [12:0] ASC_PAT [256] = '{
      13'h0490,13'h0FE0,13'h07E0,13'h0BE0,13'h03E0,13'h0DE0,13'h05E0,13'h09E0,
      13'h01E0,13'h00B8,13'h0062,13'h0EE0,13'h06E0,13'h0022,13'h0AE0,13'h02E0,
      13'h0CE0,13'h04E0,13'h08E0,13'h00E0,13'h0F60,13'h0760,13'h0B60,13'h0360,
      13'h0D60,13'h0560,13'h1240,13'h0960,13'h0160,13'h0E60,13'h0660,13'h0A60,
      13'h000F,13'h0250,13'h0038,13'h0260,13'h0050,13'h0C60,13'h0390,13'h00D8,
      13'h0042,13'h0002,13'h0058,13'h01B0,13'h007C,13'h0029,13'h003C,13'h0098,
      13'h005C,13'h0009,13'h001C,13'h006C,13'h002C,13'h004C,13'h0018,13'h000C,
      13'h0074,13'h00E8,13'h0068,13'h0460,13'h0090,13'h0034,13'h00B0,13'h0710,
      13'h0860,13'h0031,13'h0054,13'h0011,13'h0021,13'h0017,13'h0014,13'h00A8,
      13'h0028,13'h0001,13'h0310,13'h0130,13'h003E,13'h0064,13'h001E,13'h002E,
      13'h0024,13'h0510,13'h000E,13'h0036,13'h0016,13'h0044,13'h0030,13'h00C8,
      13'h01D0,13'h00D0,13'h0110,13'h0048,13'h0610,13'h0150,13'h0060,13'h0088,
      13'h0FA0,13'h0007,13'h0026,13'h0006,13'h003A,13'h001B,13'h001A,13'h002A,
      13'h000A,13'h000B,13'h0210,13'h0004,13'h0013,13'h0032,13'h0003,13'h001D,
      13'h0012,13'h0190,13'h000D,13'h0015,13'h0005,13'h0019,13'h0008,13'h0078,
      13'h00F0,13'h0070,13'h0290,13'h0410,13'h0010,13'h07A0,13'h0BA0,13'h03A0,
      13'h0240,13'h1C40,13'h0C40,13'h1440,13'h0440,13'h1840,13'h0840,13'h1040,
      13'h0040,13'h1F80,13'h0F80,13'h1780,13'h0780,13'h1B80,13'h0B80,13'h1380,
      13'h0380,13'h1D80,13'h0D80,13'h1580,13'h0580,13'h1980,13'h0980,13'h1180,
      13'h0180,13'h1E80,13'h0E80,13'h1680,13'h0680,13'h1A80,13'h0A80,13'h1280,
      13'h0280,13'h1C80,13'h0C80,13'h1480,13'h0480,13'h1880,13'h0880,13'h1080,
      13'h0080,13'h1F00,13'h0F00,13'h1700,13'h0700,13'h1B00,13'h0B00,13'h1300,
      13'h0DA0,13'h05A0,13'h09A0,13'h01A0,13'h0EA0,13'h06A0,13'h0AA0,13'h02A0,
      13'h0CA0,13'h04A0,13'h08A0,13'h00A0,13'h0F20,13'h0720,13'h0B20,13'h0320,
      13'h0D20,13'h0520,13'h0920,13'h0120,13'h0E20,13'h0620,13'h0A20,13'h0220,
      13'h0C20,13'h0420,13'h0820,13'h0020,13'h0FC0,13'h07C0,13'h0BC0,13'h03C0,
      13'h0DC0,13'h05C0,13'h09C0,13'h01C0,13'h0EC0,13'h06C0,13'h0AC0,13'h02C0,
      13'h0CC0,13'h04C0,13'h08C0,13'h00C0,13'h0F40,13'h0740,13'h0B40,13'h0340,
      13'h0300,13'h0D40,13'h1D00,13'h0D00,13'h1500,13'h0540,13'h0500,13'h1900,
      13'h0900,13'h0940,13'h1100,13'h0100,13'h1E00,13'h0E00,13'h0140,13'h1600,
      13'h0600,13'h1A00,13'h0E40,13'h0640,13'h0A40,13'h0A00,13'h1200,13'h0200,
      13'h1C00,13'h0C00,13'h1400,13'h0400,13'h1800,13'h0800,13'h1000,13'h0000};

   // class of a code: 0 fits first byte, 1 mid4, 2 mid6, 3 high byte
   function automatic logic [1:0] asc_class(input logic [7:0] c);
      logic [12:0] p;
      p = ASC_PAT[c];
      if (ASC_LEN[c] <= 4'd8) asc_class = 2'd0;
      else if (p[7:0] == 8'h00) asc_class = 2'd3;
      else if (p[5:0] != 6'h00) asc_class = 2'd1;
      else asc_class = 2'd2;
   endfunction

   function automatic logic [3:0] asc_rest(input logic [7:0] c);
      case (asc_class(c))
         2'd0: asc_rest = ASC_LEN[c];
         2'd1: asc_rest = 4'(ASC_LEN[c] - 4'd4);
         2'd2: asc_rest = 4'(ASC_LEN[c] - 4'd6);
         default: asc_rest = 4'(ASC_LEN[c] - 4'd8);
      endcase
   endfunction

   // lowest symbol wins, as the table build fills from the top down
   function automatic logic [7:0] asc_first(input logic [7:0] b);
      logic [7:0] r;
      logic [12:0] p;
      logic [7:0] m;
      r = 8'h00;
      for (int c = 255; c >= 0; c--) begin
         p = ASC_PAT[c];
         m = 8'((9'd1 << ASC_LEN[c][3:0]) - 9'd1);
         if (asc_class(8'(c)) == 2'd0) begin
            if ((b & m) == p[7:0]) r = 8'(c);
         end else if (asc_class(8'(c)) != 2'd3) begin
            if (b == p[7:0]) r = 8'hFF;
         end
      end
      asc_first = r;
   endfunction

   function automatic logic [7:0] asc_sub(input logic [7:0] b, input logic [1:0] cls);
      logic [7:0] r;
      logic [12:0] p;
      logic [7:0] m;
      logic [7:0] v;
      logic [3:0] rl;
      r = 8'h00;
      for (int c = 255; c >= 0; c--) begin
         if (asc_class(8'(c)) == cls) begin
            p = ASC_PAT[c];
            rl = asc_rest(8'(c));
            m = (rl >= 4'd8) ? 8'hFF : 8'((9'd1 << rl) - 9'd1);
            case (cls)
               2'd1: v = 8'(p >> 4);
               2'd2: v = 8'(p >> 6);
               default: v = 8'(p >> 8);
            endcase
            if ((b & m) == v) r = 8'(c);
         end
      end
      asc_sub = r;
   endfunction

endpackage

### rtl/implode_stream_decompressor.sv
//------------------------------------------------------------------------------
// implode_stream_decompressor
// Implode format decompressor: one compressed request in, a run of bytes out.
//------------------------------------------------------------------------------
// Steps: an accept, then the decode steps, an emit step per literal byte, a window
// read and then a write for each copied byte, then a closing result.
// A request emits up to BURST bytes.
// Flow: one request at a time; bytes pass a one-entry stage so the final
// byte carries last, and byte emits hold while the output is full and rsp_ready is low.
// Synchronous reset clears control state; unwritten window entries read zero.
`include "implode_stream_decompressor_macros.svh"

module implode_stream_decompressor #(
   parameter int WINDOW_DEPTH = 4096,
   parameter int BURST        = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_last,
   output logic [2:0] rsp_status
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int CW = $clog2(BURST + 1);

   isd_pkg::seq_type   seq_ff, seq_in;
   isd_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  hcount_ff, hcount_in;
   logic        ascii_ff, ascii_in;
   logic [2:0]  dict_ff, dict_in;
   logic [15:0] buf_ff, buf_in;
   logic [3:0]  spare_ff, spare_in;
   logic [3:0]  lcode_ff, lcode_in;
   logic [7:0]  asym_ff, asym_in;
   logic [7:0]  held_ff, held_in;
   logic [9:0]  left_ff, left_in;
   logic [AW-1:0] src_ff, src_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic        feed_ff, feed_in;
   logic [7:0]  fbyte_ff;
   logic        fin_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [2:0]  stat_ff, stat_in;
   logic        wrap_ff, wrap_in;
   logic        stg_v_ff, stg_v_in;
   logic [7:0]  stg_b_ff, stg_b_in;

   logic        ov_ff, ov_in;
   logic [7:0]  ob_ff, ob_in;
   logic        ohas_ff, ohas_in;
   logic        olast_ff, olast_in;
   logic [2:0]  ost_ff, ost_in;

   logic [7:0]  win_mem [WINDOW_DEPTH];
   logic [7:0]  rd_data_ff;
   logic        rd_vld_ff;
   logic        wr_en;
   logic [7:0]  wr_data;
   logic        rd_en;

   logic        out_free;
   logic        emit_ok;
   logic        accept;

   assign out_free  = !ov_ff || rsp_ready;
   assign emit_ok   = !stg_v_ff || out_free;
   assign req_ready = (seq_ff == isd_pkg::SQ_IDLE);
   assign accept    = req_valid && req_ready;

   assign rsp_valid    = ov_ff;
   assign rsp_out_byte = ob_ff;
   assign rsp_has_byte = ohas_ff;
   assign rsp_last     = olast_ff;
   assign rsp_status   = ost_ff;

   always_ff @(posedge clock) begin
      if (wr_en) win_mem[wp_ff] <= wr_data;
      if (rd_en) begin
         rd_data_ff <= win_mem[src_ff];
         rd_vld_ff  <= wrap_ff || (src_ff < wp_ff);
      end
   end

   // bit dropping helper results
   logic [3:0]  drop_n;
   logic        drop_ok;
   logic        drop_used;
   logic [15:0] drop_buf;
   logic [3:0]  drop_spare;

   always_comb begin
      logic [15:0] t;
      logic [3:0]  n;
      n = (drop_n > 4'd8) ? 4'd8 : drop_n;
      drop_ok    = 1'b1;
      drop_used  = 1'b0;
      drop_buf   = buf_ff;
      drop_spare = spare_ff;
      t = '0;
      if (n == 4'd0) begin
         drop_ok = 1'b1;
      end else if (n <= spare_ff) begin
         drop_spare = 4'(spare_ff - n);
         drop_buf   = buf_ff >> n;
      end else if (!feed_ff) begin
         drop_ok = 1'b0;
      end else begin
         drop_used  = 1'b1;
         t          = (buf_ff >> spare_ff) | {fbyte_ff, 8'h00};
         drop_buf   = t >> 4'(n - spare_ff);
         drop_spare = 4'(spare_ff + 4'd8 - n);
      end
   end

   logic [3:0] lc_now;
   logic [5:0] dc_now;
   logic [7:0] af_now;
   logic [9:0] lx_val;
   logic [11:0] dist_d;
   logic [3:0] dl_bits;
   logic [7:0] asub_b;
   logic [1:0] asub_c;
   logic [7:0] asub_r;

   assign lc_now = isd_pkg::len_lut(buf_ff[7:0]);
   assign dc_now = isd_pkg::dist_lut(buf_ff[7:0]);
   assign af_now = isd_pkg::asc_first(buf_ff[7:0]);
   assign asub_r = isd_pkg::asc_sub(asub_b, asub_c);

   always_comb begin
      asub_b = drop_buf[7:0];
      asub_c = 2'd3;
      case (phase_ff)
         isd_pkg::PH_A4: asub_c = 2'd1;
         isd_pkg::PH_A6: begin
            asub_c = 2'd2;
            asub_b = {1'b0, drop_buf[6:0]};
         end
         default: asub_c = 2'd3;
      endcase
   end

   always_comb begin
      logic [3:0] ex;
      ex = isd_pkg::len_extra(lcode_ff);
      lx_val = 10'(isd_pkg::len_start(lcode_ff)) +
               10'(buf_ff[7:0] & 8'((9'd1 << ex) - 9'd1));
      if (left_ff == 10'd2) begin
         dl_bits = 4'd2;
         dist_d  = {4'd0, src_ff[5:0], buf_ff[1:0]};
      end else begin
         dl_bits = {1'b0, dict_ff};
         dist_d  = 12'(({6'd0, src_ff[5:0]} << dict_ff) |
                   (12'(buf_ff[5:0]) & 12'((13'd1 << dict_ff) - 13'd1)));
      end
   end

   // next state
   always_comb begin
      logic [9:0] litv;
      seq_in   = seq_ff;
      phase_in = phase_ff;
      hcount_in = hcount_ff;
      ascii_in = ascii_ff;
      dict_in  = dict_ff;
      buf_in   = buf_ff;
      spare_in = spare_ff;
      lcode_in = lcode_ff;
      asym_in  = asym_ff;
      held_in  = held_ff;
      left_in  = left_ff;
      src_in   = src_ff;
      wp_in    = wp_ff;
      feed_in  = feed_ff;
      cnt_in   = cnt_ff;
      stat_in  = stat_ff;
      stg_v_in = stg_v_ff;
      stg_b_in = stg_b_ff;
      ov_in    = ov_ff && !rsp_ready;
      ob_in    = ob_ff;
      ohas_in  = ohas_ff;
      olast_in = olast_ff;
      ost_in   = ost_ff;
      wr_en    = 1'b0;
      wr_data  = held_ff;
      rd_en    = 1'b0;
      drop_n   = 4'd0;
      litv     = '0;

      case (seq_ff)
         isd_pkg::SQ_IDLE: begin
            if (accept) begin
               cnt_in  = '0;
               stat_in = isd_pkg::ST_NEED;
               feed_in = 1'b0;
               seq_in  = isd_pkg::SQ_FIN;
               case (phase_ff)
                  isd_pkg::PH_DONE: stat_in = isd_pkg::ST_DONE;
                  isd_pkg::PH_ERR:  stat_in = lcode_ff[2:0];
                  isd_pkg::PH_HDR: begin
                     if (req_kind == isd_pkg::KIND_DATA) begin
                        if (hcount_ff == 2'd0) begin
                           ascii_in  = req_data_byte[0];
                           buf_in    = (req_data_byte > 8'd1) ? 16'h0100 : 16'h0000;
                           hcount_in = 2'd1;
                        end else if (hcount_ff == 2'd1) begin
                           dict_in = (req_data_byte >= 8'd4 && req_data_byte <= 8'd6) ?
                                     req_data_byte[2:0] : 3'd0;
                           hcount_in = 2'd2;
                        end else begin
                           hcount_in = 2'd3;
                           buf_in    = {8'h00, req_data_byte};
                           spare_in  = 4'd0;
                           if (dict_ff == 3'd0) begin
                              stat_in = isd_pkg::ST_BADDICT;
                              lcode_in = 4'(isd_pkg::ST_BADDICT);
                              phase_in = isd_pkg::PH_ERR;
                           end else if (buf_ff[8]) begin
                              stat_in = isd_pkg::ST_BADMODE;
                              lcode_in = 4'(isd_pkg::ST_BADMODE);
                              phase_in = isd_pkg::PH_ERR;
                           end else begin
                              phase_in = isd_pkg::PH_FLAG;
                           end
                        end
                     end else if (req_kind == isd_pkg::KIND_END) begin
                        lcode_in = 4'(isd_pkg::ST_SHORT);
                        phase_in = isd_pkg::PH_ERR;
                        stat_in  = isd_pkg::ST_SHORT;
                     end
                  end
                  default: begin
                     if (req_kind == isd_pkg::KIND_DATA &&
                         (phase_ff == isd_pkg::PH_EMIT || phase_ff == isd_pkg::PH_COPY)) begin
                        stat_in = isd_pkg::ST_BUSY;
                     end else begin
                        feed_in = (req_kind == isd_pkg::KIND_DATA);
                        seq_in  = isd_pkg::SQ_RUN;
                     end
                  end
               endcase
            end
         end

         isd_pkg::SQ_RUN: begin
            case (phase_ff)
               isd_pkg::PH_FLAG: begin
                  drop_n = 4'd1;
                  if (drop_ok) begin
                     phase_in = buf_ff[0] ? isd_pkg::PH_LEN :
                                (ascii_ff ? isd_pkg::PH_ASTART : isd_pkg::PH_LITB);
                  end
               end
               isd_pkg::PH_LEN: begin
                  lcode_in = lc_now;
                  drop_n = isd_pkg::len_len(lc_now);
                  if (drop_ok) begin
                     if (isd_pkg::len_extra(lc_now) == 4'd0) begin
                        litv = 10'(isd_pkg::len_start(lc_now));
                        if (litv >= isd_pkg::LIT_END) begin
                           phase_in = isd_pkg::PH_DONE;
                           stat_in  = isd_pkg::ST_DONE;
                           seq_in   = isd_pkg::SQ_FIN;
                        end else begin
                           left_in  = 10'(litv - isd_pkg::LEN_BIAS);
                           phase_in = isd_pkg::PH_DIST;
                        end
                     end else begin
                        phase_in = isd_pkg::PH_LENX;
                     end
                  end
               end
               isd_pkg::PH_LENX: begin
                  drop_n = isd_pkg::len_extra(lcode_ff);
                  if (drop_ok) begin
                     litv = lx_val;
                     if (litv >= isd_pkg::LIT_END) begin
                        phase_in = isd_pkg::PH_DONE;
                        stat_in  = isd_pkg::ST_DONE;
                        seq_in   = isd_pkg::SQ_FIN;
                     end else begin
                        left_in  = 10'(litv - isd_pkg::LEN_BIAS);
                        phase_in = isd_pkg::PH_DIST;
                     end
                  end
               end
               isd_pkg::PH_LITB: begin
                  drop_n = 4'd8;
                  if (drop_ok) begin
                     held_in  = buf_ff[7:0];
                     phase_in = isd_pkg::PH_EMIT;
                  end
               end
               isd_pkg::PH_ASTART: begin
                  if (buf_ff[7:0] != 8'h00) begin
                     if (af_now == 8'hFF) begin
                        phase_in = (buf_ff[5:0] != 6'h00) ? isd_pkg::PH_A4 : isd_pkg::PH_A6;
                     end else begin
                        asym_in  = af_now;
                        phase_in = isd_pkg::PH_AFIN;
                     end
                  end else begin
                     drop_n = 4'd8;
                     if (drop_ok) begin
                        asym_in  = asub_r;
                        phase_in = isd_pkg::PH_AFIN;
                     end
                  end
               end
               isd_pkg::PH_A4: begin
                  drop_n = 4'd4;
                  if (drop_ok) begin
                     asym_in  = asub_r;
                     phase_in = isd_pkg::PH_AFIN;
                  end
               end
               isd_pkg::PH_A6: begin
                  drop_n = 4'd6;
                  if (drop_ok) begin
                     asym_in  = asub_r;
                     phase_in = isd_pkg::PH_AFIN;
                  end
               end
               isd_pkg::PH_AFIN: begin
                  drop_n = isd_pkg::asc_rest(asym_ff);
                  if (drop_ok) begin
                     held_in  = asym_ff;
                     phase_in = isd_pkg::PH_EMIT;
                  end
               end
               isd_pkg::PH_DIST: begin
                  drop_n = isd_pkg::dist_len(dc_now);
                  if (drop_ok) begin
                     src_in   = AW'(dc_now);
                     phase_in = isd_pkg::PH_DLOW;
                  end
               end
               isd_pkg::PH_DLOW: begin
                  drop_n = dl_bits;
                  if (drop_ok) begin
                     src_in   = AW'(wp_ff - AW'(dist_d) - AW'(1));
                     phase_in = isd_pkg::PH_COPY;
                  end
               end
               isd_pkg::PH_EMIT: begin
                  if (cnt_ff >= CW'(BURST)) begin
                     stat_in = isd_pkg::ST_PEND;
                     seq_in  = isd_pkg::SQ_FIN;
                  end else if (emit_ok) begin
                     wr_en    = 1'b1;
                     wr_data  = held_ff;
                     wp_in    = AW'(wp_ff + AW'(1));
                     cnt_in   = CW'(cnt_ff + CW'(1));
                     if (stg_v_ff) begin
                        ov_in    = 1'b1;
                        ob_in    = stg_b_ff;
                        ohas_in  = 1'b1;
                        olast_in = 1'b0;
                        ost_in   = isd_pkg::ST_NEED;
                     end
                     stg_v_in = 1'b1;
                     stg_b_in = held_ff;
                     phase_in = isd_pkg::PH_FLAG;
                  end
               end
               isd_pkg::PH_COPY: begin
                  if (left_ff == 10'd0) begin
                     phase_in = isd_pkg::PH_FLAG;
                  end else if (cnt_ff >= CW'(BURST)) begin
                     stat_in = isd_pkg::ST_PEND;
                     seq_in  = isd_pkg::SQ_FIN;
                  end else begin
                     rd_en  = 1'b1;
                     seq_in = isd_pkg::SQ_READ;
                  end
               end
               default: begin
                  seq_in = isd_pkg::SQ_FIN;
               end
            endcase
            if (drop_n != 4'd0 || phase_ff == isd_pkg::PH_FLAG) begin
               if (drop_ok) begin
                  buf_in   = drop_buf;
                  spare_in = drop_spare;
                  if (drop_used) feed_in = 1'b0;
               end else begin
                  seq_in = isd_pkg::SQ_FIN;
                  if (fin_ff) begin
                     phase_in = isd_pkg::PH_DONE;
                     stat_in  = isd_pkg::ST_DONE;
                  end else begin
                     stat_in  = isd_pkg::ST_NEED;
                  end
               end
            end
         end

         isd_pkg::SQ_READ: begin
            if (emit_ok) begin
               wr_en    = 1'b1;
               wr_data  = rd_vld_ff ? rd_data_ff : 8'h00;
               wp_in    = AW'(wp_ff + AW'(1));
               src_in   = AW'(src_ff + AW'(1));
               left_in  = 10'(left_ff - 10'd1);
               cnt_in   = CW'(cnt_ff + CW'(1));
               if (stg_v_ff) begin
                  ov_in    = 1'b1;
                  ob_in    = stg_b_ff;
                  ohas_in  = 1'b1;
                  olast_in = 1'b0;
                  ost_in   = isd_pkg::ST_NEED;
               end
               stg_v_in = 1'b1;
               stg_b_in = wr_data;
               seq_in   = isd_pkg::SQ_RUN;
            end
         end

         default: begin
            // closing result: the staged byte carries last, else a byte-less one
            if (out_free) begin
               ov_in    = 1'b1;
               ob_in    = stg_v_ff ? stg_b_ff : 8'h00;
               ohas_in  = stg_v_ff;
               olast_in = 1'b1;
               ost_in   = stat_ff;
               stg_v_in = 1'b0;
               seq_in   = isd_pkg::SQ_IDLE;
            end
         end
      endcase
      wrap_in = wrap_ff || (wr_en && (wp_ff == {AW{1'b1}}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= isd_pkg::SQ_IDLE;
         phase_ff  <= isd_pkg::PH_HDR;
         hcount_ff <= '0;
         ascii_ff  <= 1'b0;
         dict_ff   <= '0;
         buf_ff    <= '0;
         spare_ff  <= '0;
         lcode_ff  <= '0;
         asym_ff   <= '0;
         held_ff   <= '0;
         left_ff   <= '0;
         src_ff    <= '0;
         wp_ff     <= '0;
         feed_ff   <= 1'b0;
         cnt_ff    <= '0;
         stat_ff   <= '0;
         ov_ff     <= 1'b0;
         fin_ff    <= 1'b0;
         wrap_ff   <= 1'b0;
         stg_v_ff  <= 1'b0;
      end else begin
         seq_ff    <= seq_in;
         phase_ff  <= phase_in;
         hcount_ff <= hcount_in;
         ascii_ff  <= ascii_in;
         dict_ff   <= dict_in;
         buf_ff    <= buf_in;
         spare_ff  <= spare_in;
         lcode_ff  <= lcode_in;
         asym_ff   <= asym_in;
         held_ff   <= held_in;
         left_ff   <= left_in;
         src_ff    <= src_in;
         wp_ff     <= wp_in;
         feed_ff   <= feed_in;
         cnt_ff    <= cnt_in;
         stat_ff   <= stat_in;
         ov_ff     <= ov_in;
         if (accept) fin_ff <= (req_kind == isd_pkg::KIND_END);
         wrap_ff   <= wrap_in;
         stg_v_ff  <= stg_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) fbyte_ff <= req_data_byte;
      stg_b_ff <= stg_b_in;
      ob_ff    <= ob_in;
      ohas_ff  <= ohas_in;
      olast_ff <= olast_in;
      ost_ff   <= ost_in;
   end

   `ISD_ASSERT(a_idle_no_byte, clock, reset, (seq_ff == isd_pkg::SQ_IDLE) |-> !stg_v_ff, "idle with a staged byte")
   `ISD_ASSERT(a_burst_cap, clock, reset, cnt_ff <= CW'(BURST), "burst count exceeded")
   `ISD_ASSERT(a_read_from_copy, clock, reset, (seq_ff == isd_pkg::SQ_READ) |-> (phase_ff == isd_pkg::PH_COPY), "window read outside copy")
   `ISD_ASSERT_NR(a_reset_idle, clock, reset |=> (seq_ff == isd_pkg::SQ_IDLE && !ov_ff), "not idle after reset")

endmodule

### tb/sv/isd_stream_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// isd_stream_checker
// Watches both channels of the decompressor, predicts the output of every
// accepted request from its own decoder state and compares each response.
//------------------------------------------------------------------------------
module isd_stream_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_has_byte,
   input  logic       rsp_last,
   input  logic [2:0] rsp_status,
   output int         fail_count,
   output int         expected_left,
   output logic       output_pending,
   output int         bytes_out
);

   localparam int BURST = 64;
   localparam logic [3:0] LEN_BITS  [16] = '{3,2,3,3,4,4,4,5,5,5,5,6,6,6,7,7};
   localparam logic [7:0] LEN_PAT   [16] = '{8'h05,8'h03,8'h01,8'h06,8'h0A,8'h02,8'h0C,8'h14,
                                            8'h04,8'h18,8'h08,8'h30,8'h10,8'h20,8'h40,8'h00};
   localparam logic [3:0] LEN_EXTRA [16] = '{0,0,0,0,0,0,0,0,1,2,3,4,5,6,7,8};
   localparam logic [8:0] LEN_BASE  [16] = '{0,1,2,3,4,5,6,7,8,9'h0A,9'h0E,9'h16,9'h26,
                                            9'h46,9'h86,9'h106};

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       last;
      logic [2:0] status;
   } rsp_item_type;

   rsp_item_type expected_q[$];
   logic [7:0]   step_bytes[$];

   logic [3:0] len_lut [256];
   logic [5:0] dist_lut [256];
   logic [7:0] asc_first [256];
   logic [7:0] asc_mid4 [256];
   logic [7:0] asc_mid6 [128];
   logic [7:0] asc_high [256];
   logic [3:0] asc_rest [256];

   isd_pkg::phase_type phase;
   logic [1:0]  hdr_cnt;
   logic        ascii_mode;
   logic [2:0]  dict_bits;
   logic [15:0] bitbuf;
   logic [3:0]  spare;
   logic [3:0]  len_code;
   logic [7:0]  asym;
   logic [7:0]  held;
   logic [9:0]  copy_left;
   logic [11:0] copy_src;
   logic [11:0] wr_ptr;
   logic [7:0]  window [4096];
   logic        feed_valid;
   logic [7:0]  feed_byte;

   initial begin
      fail_count = 0;
      expected_left = 0;
      output_pending = 1'b0;
      bytes_out = 0;
   end

   function automatic int dist_code_bits(input int c);
      if (c == 0) return 2;
      if (c < 3) return 4;
      if (c < 7) return 5;
      if (c < 22) return 6;
      if (c < 48) return 7;
      return 8;
   endfunction

   initial begin
      int unsigned b, p;
      for (int k = 0; k < 256; k++) begin
         len_lut[k] = 0; dist_lut[k] = 0; asc_first[k] = 0; asc_mid4[k] = 0;
         asc_high[k] = 0; asc_rest[k] = isd_pkg::ASC_LEN[k];
         if (k < 128) asc_mid6[k] = 0;
      end
      for (int i = 0; i < 16; i++)
         for (int k = LEN_PAT[i]; k < 256; k += 1 << LEN_BITS[i]) len_lut[k] = 4'(i);
      for (int i = 0; i < 64; i++)
         for (int k = isd_pkg::DIST_PAT[i]; k < 256; k += 1 << dist_code_bits(i))
            dist_lut[k] = 6'(i);
      for (int c = 255; c >= 0; c--) begin
         b = isd_pkg::ASC_LEN[c];
         p = isd_pkg::ASC_PAT[c];
         if (b <= 8) begin
            for (int k = p; k < 256; k += 1 << b) asc_first[k] = 8'(c);
         end else if ((p & 8'hFF) != 0) begin
            asc_first[p & 8'hFF] = 8'hFF;
            if ((p & 6'h3F) != 0) begin
               b = b - 4; asc_rest[c] = 4'(b);
               for (int k = p >> 4; k < 256; k += 1 << b) asc_mid4[k] = 8'(c);
            end else begin
               b = b - 6; asc_rest[c] = 4'(b);
               for (int k = p >> 6; k < 128; k += 1 << b) asc_mid6[k] = 8'(c);
            end
         end else begin
            b = b - 8; asc_rest[c] = 4'(b);
            for (int k = p >> 8; k < 256; k += 1 << b) asc_high[k] = 8'(c);
         end
      end
   end

   // consume n bits; pulls in the request byte when the buffer runs dry
   function automatic bit take_bits(input int unsigned n);
      logic [15:0] merged;
      if (n > 8) n = 8;
      if (n == 0) return 1'b1;
      if (n <= spare) begin
         spare = 4'(spare - n);
         bitbuf = bitbuf >> n;
         return 1'b1;
      end
      if (!feed_valid) return 1'b0;
      feed_valid = 1'b0;
      merged = (bitbuf >> spare) | {feed_byte, 8'h00};
      bitbuf = merged >> (n - spare);
      spare = 4'(spare + 8 - n);
      return 1'b1;
   endfunction

   function automatic void set_length(input int unsigned v);
      if (v + 256 >= 10'h305) begin
         phase = isd_pkg::PH_DONE;
         return;
      end
      copy_left = 10'(v + 256 - 8'hFE);
      phase = isd_pkg::PH_DIST;
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      step_bytes.push_back(b);
      window[wr_ptr] = b;
      wr_ptr = wr_ptr + 12'd1;
   endfunction

   task automatic decode_run(input bit finished, output isd_pkg::status_type st);
      int unsigned t, x, d;
      bit stalled, stop;
      stalled = 0;
      stop = 0;
      st = isd_pkg::ST_NEED;
      while (!stop && !stalled) begin
         case (phase)
            isd_pkg::PH_FLAG: begin
               t = bitbuf[0];
               if (!take_bits(1)) stalled = 1;
               else phase = t ? isd_pkg::PH_LEN :
                            (ascii_mode ? isd_pkg::PH_ASTART : isd_pkg::PH_LITB);
            end
            isd_pkg::PH_LEN: begin
               len_code = len_lut[bitbuf[7:0]];
               if (!take_bits(LEN_BITS[len_code])) stalled = 1;
               else begin
                  if (LEN_EXTRA[len_code] == 0) set_length(LEN_BASE[len_code]);
                  else phase = isd_pkg::PH_LENX;
                  if (phase == isd_pkg::PH_DONE) begin st = isd_pkg::ST_DONE; stop = 1; end
               end
            end
            isd_pkg::PH_LENX: begin
               t = LEN_EXTRA[len_code];
               x = bitbuf & ((1 << t) - 1);
               if (!take_bits(t)) stalled = 1;
               else begin
                  set_length(LEN_BASE[len_code] + x);
                  if (phase == isd_pkg::PH_DONE) begin st = isd_pkg::ST_DONE; stop = 1; end
               end
            end
            isd_pkg::PH_LITB: begin
               t = bitbuf[7:0];
               if (!take_bits(8)) stalled = 1;
               else begin held = 8'(t); phase = isd_pkg::PH_EMIT; end
            end
            isd_pkg::PH_ASTART: begin
               if (bitbuf[7:0] != 0) begin
                  t = asc_first[bitbuf[7:0]];
                  if (t == 8'hFF) phase = (bitbuf[5:0] != 0) ? isd_pkg::PH_A4 : isd_pkg::PH_A6;
                  else begin asym = 8'(t); phase = isd_pkg::PH_AFIN; end
               end else if (!take_bits(8)) stalled = 1;
               else begin asym = asc_high[bitbuf[7:0]]; phase = isd_pkg::PH_AFIN; end
            end
            isd_pkg::PH_A4: begin
               if (!take_bits(4)) stalled = 1;
               else begin asym = asc_mid4[bitbuf[7:0]]; phase = isd_pkg::PH_AFIN; end
            end
            isd_pkg::PH_A6: begin
               if (!take_bits(6)) stalled = 1;
               else begin asym = asc_mid6[bitbuf[6:0]]; phase = isd_pkg::PH_AFIN; end
            end
            isd_pkg::PH_AFIN: begin
               if (!take_bits(asc_rest[asym])) stalled = 1;
               else begin held = asym; phase = isd_pkg::PH_EMIT; end
            end
            isd_pkg::PH_DIST: begin
               t = dist_lut[bitbuf[7:0]];
               if (!take_bits(dist_code_bits(t))) stalled = 1;
               else begin copy_src = 12'(t); phase = isd_pkg::PH_DLOW; end
            end
            isd_pkg::PH_DLOW: begin
               t = copy_src[5:0];
               if (copy_left == 2) begin
                  d = (t << 2) | bitbuf[1:0];
                  x = 2;
               end else begin
                  d = (t << dict_bits) | (bitbuf & ((1 << dict_bits) - 1));
                  x = dict_bits;
               end
               if (!take_bits(x)) stalled = 1;
               else begin copy_src = 12'(wr_ptr - d - 1); phase = isd_pkg::PH_COPY; end
            end
            isd_pkg::PH_EMIT: begin
               if (step_bytes.size() >= BURST) begin st = isd_pkg::ST_PEND; stop = 1; end
               else begin put_byte(held); phase = isd_pkg::PH_FLAG; end
            end
            isd_pkg::PH_COPY: begin
               while (copy_left > 0 && step_bytes.size() < BURST) begin
                  put_byte(window[copy_src]);
                  copy_src = copy_src + 12'd1;
                  copy_left = copy_left - 10'd1;
               end
               if (copy_left > 0) begin st = isd_pkg::ST_PEND; stop = 1; end
               else phase = isd_pkg::PH_FLAG;
            end
            default: stop = 1;
         endcase
      end
      if (stalled) begin
         if (finished) begin phase = isd_pkg::PH_DONE; st = isd_pkg::ST_DONE; end
         else st = isd_pkg::ST_NEED;
      end
   endtask

   task automatic predict_request(input logic [1:0] kind, input logic [7:0] data);
      isd_pkg::status_type st;
      rsp_item_type        item;
      st = isd_pkg::ST_NEED;
      step_bytes.delete();
      if (phase == isd_pkg::PH_DONE) st = isd_pkg::ST_DONE;
      else if (phase == isd_pkg::PH_ERR) st = isd_pkg::status_type'(len_code[2:0]);
      else if (phase == isd_pkg::PH_HDR) begin
         if (kind == isd_pkg::KIND_DATA) begin
            if (hdr_cnt == 0) begin
               ascii_mode = data[0];
               bitbuf = (data > 1) ? 16'h0100 : 16'h0000;
               hdr_cnt = 1;
            end else if (hdr_cnt == 1) begin
               dict_bits = (data >= 4 && data <= 6) ? data[2:0] : 3'd0;
               hdr_cnt = 2;
            end else begin
               hdr_cnt = 3;
               if (dict_bits == 0) st = isd_pkg::ST_BADDICT;
               else if (bitbuf[8]) st = isd_pkg::ST_BADMODE;
               bitbuf = {8'h00, data};
               spare = 0;
               if (st != isd_pkg::ST_NEED) begin
                  len_code = {1'b0, st};
                  phase = isd_pkg::PH_ERR;
               end else phase = isd_pkg::PH_FLAG;
            end
         end else if (kind == isd_pkg::KIND_END) begin
            len_code = {1'b0, isd_pkg::ST_SHORT};
            phase = isd_pkg::PH_ERR;
            st = isd_pkg::ST_SHORT;
         end
      end else if (kind == isd_pkg::KIND_DATA &&
                   (phase == isd_pkg::PH_EMIT || phase == isd_pkg::PH_COPY)) begin
         st = isd_pkg::ST_BUSY;
      end else begin
         feed_valid = (kind == isd_pkg::KIND_DATA);
         feed_byte = data;
         decode_run(kind == isd_pkg::KIND_END, st);
         feed_valid = 1'b0;
      end
      foreach (step_bytes[i]) begin
         item.out_byte = step_bytes[i];
         item.has_byte = 1'b1;
         item.last     = (i == step_bytes.size() - 1);
         item.status   = item.last ? st : isd_pkg::ST_NEED;
         expected_q.push_back(item);
      end
      if (step_bytes.size() == 0) begin
         item = '{out_byte: 8'h00, has_byte: 1'b0, last: 1'b1, status: st};
         expected_q.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         phase = isd_pkg::PH_HDR; hdr_cnt = 0; ascii_mode = 0; dict_bits = 0; bitbuf = 0;
         spare = 0; len_code = 0; asym = 0; held = 0; copy_left = 0; copy_src = 0;
         wr_ptr = 0; feed_valid = 0; feed_byte = 0;
         for (int k = 0; k < 4096; k++) window[k] = 8'h00;
         expected_q.delete();
      end else begin
         if (req_valid && req_ready) predict_request(req_kind, req_data_byte);
         if (rsp_valid && rsp_ready) begin
            if (rsp_has_byte) bytes_out++;
            if (expected_q.size() == 0) begin
               fail_count++;
               $display("%0t unexpected response: byte=%h has=%b last=%b status=%0d",
                        $time, rsp_out_byte, rsp_has_byte, rsp_last, rsp_status);
            end else begin
               want = expected_q.pop_front();
               if (want != {rsp_out_byte, rsp_has_byte, rsp_last, rsp_status}) begin
                  fail_count++;
                  $display("%0t mismatch: expected byte=%h has=%b last=%b status=%0d, %s",
                           $time, want.out_byte, want.has_byte, want.last, want.status,
                           $sformatf("got byte=%h has=%b last=%b status=%0d",
                           rsp_out_byte, rsp_has_byte, rsp_last, rsp_status));
               end
            end
         end
      end
      expected_left  <= expected_q.size();
      output_pending <= (phase == isd_pkg::PH_EMIT || phase == isd_pkg::PH_COPY);
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb
// Builds one implode stream (directed tokens, then random ones, and a random
// ending variant), feeds it with random idles, continues and at most one
// rejected byte, and reports the checker's verdict.
//------------------------------------------------------------------------------
module tb;

   localparam logic [1:0] KIND_ALIAS_CONT = 2'd3;
   localparam logic [3:0] LEN_BITS  [16] = '{3,2,3,3,4,4,4,5,5,5,5,6,6,6,7,7};
   localparam logic [7:0] LEN_PAT   [16] = '{8'h05,8'h03,8'h01,8'h06,8'h0A,8'h02,8'h0C,8'h14,
                                            8'h04,8'h18,8'h08,8'h30,8'h10,8'h20,8'h40,8'h00};
   localparam logic [3:0] LEN_EXTRA [16] = '{0,0,0,0,0,0,0,0,1,2,3,4,5,6,7,8};
   localparam logic [8:0] LEN_BASE  [16] = '{0,1,2,3,4,5,6,7,8,9'h0A,9'h0E,9'h16,9'h26,
                                            9'h46,9'h86,9'h106};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_kind = isd_pkg::KIND_CONT;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_last;
   logic [2:0] rsp_status;
   int         fail_count;
   int         expected_left;
   logic       output_pending;
   int         bytes_out;

   bit         calm = 1'b0;
   bit         rejected = 1'b0;
   bit         code_bits[$];
   logic [7:0] stream_bytes[$];
   int         request_count = 0;
   logic       ascii_mode;
   int         dict_bits;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   implode_stream_decompressor uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte), .rsp_has_byte(rsp_has_byte),
      .rsp_last(rsp_last), .rsp_status(rsp_status)
   );

   isd_stream_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte), .rsp_has_byte(rsp_has_byte),
      .rsp_last(rsp_last), .rsp_status(rsp_status),
      .fail_count(fail_count), .expected_left(expected_left),
      .output_pending(output_pending), .bytes_out(bytes_out)
   );

   always @(posedge clock) rsp_ready <= calm || ($urandom_range(0, 99) >= 24);

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int dist_code_bits(input int c);
      if (c == 0) return 2;
      if (c < 3) return 4;
      if (c < 7) return 5;
      if (c < 22) return 6;
      if (c < 48) return 7;
      return 8;
   endfunction

   // LSB first
   function automatic void push_bits(input int unsigned v, input int n);
      for (int i = 0; i < n; i++) code_bits.push_back((v >> i) & 1);
   endfunction

   function automatic void add_literal(input logic [7:0] b);
      push_bits(0, 1);
      if (ascii_mode) push_bits(isd_pkg::ASC_PAT[b], isd_pkg::ASC_LEN[b]);
      else push_bits(b, 8);
   endfunction

   function automatic void add_match(input int unsigned len, input int unsigned gap);
      int unsigned v, c, lob, hi;
      v = len - 2;
      c = 0;
      for (int k = 0; k < 16; k++) if (LEN_BASE[k] <= v) c = k;
      push_bits(1, 1);
      push_bits(LEN_PAT[c], LEN_BITS[c]);
      push_bits(v - LEN_BASE[c], LEN_EXTRA[c]);
      lob = (len == 2) ? 2 : dict_bits;
      hi = gap >> lob;
      push_bits(isd_pkg::DIST_PAT[hi], dist_code_bits(hi));
      push_bits(gap & ((1 << lob) - 1), lob);
   endfunction

   function automatic int unsigned max_gap(input int unsigned len);
      return (len == 2) ? 255 : (64 << dict_bits) - 1;
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
      if (!calm && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      request_count++;
   endtask

   // idling first lets the checker's view settle; continues go in while output is pending
   task automatic drain_then_send(input logic [1:0] kind, input logic [7:0] b);
      req_valid <= 1'b0;
      @(posedge clock);
      while (output_pending) begin
         if (!rejected) begin
            rejected = 1'b1;
            send_item(isd_pkg::KIND_DATA, 8'($urandom));
         end else send_item(($urandom_range(0, 3) == 0) ? KIND_ALIAS_CONT
                                                        : isd_pkg::KIND_CONT, 8'h00);
         req_valid <= 1'b0;
         @(posedge clock);
      end
      send_item(kind, b);
   endtask

   initial begin
      int unsigned len, variant;
      logic [7:0] b;
      ascii_mode = 1'($urandom_range(0, 1));
      dict_bits = $urandom_range(4, 6);
      variant = $urandom_range(0, 3);

      add_literal(8'h00); add_literal(8'hFF); add_literal(8'h20); add_literal(8'h1A);
      add_literal(8'hE0); add_literal(8'h41); add_literal(8'h7F); add_literal(8'h80);
      add_match(2, 0); add_match(2, 255); add_match(3, max_gap(3)); add_match(8, 0);
      add_match(518, 1); add_literal(8'h0A); add_match(10, 5); add_match(69, 3);
      add_match(262, 7); add_match(4, max_gap(4)); add_literal(8'hAA); add_literal(8'h55);
      while (code_bits.size() < 8 * 135) begin
         if ($urandom_range(0, 99) < 55) begin
            b = ascii_mode && $urandom_range(0, 3) != 0 ? 8'($urandom_range(32, 126))
                                                        : 8'($urandom);
            add_literal(b);
         end else begin
            len = $urandom_range(0, 99);
            len = (len < 85) ? $urandom_range(2, 16)
                : (len < 97) ? $urandom_range(17, 80) : $urandom_range(81, 518);
            add_match(len, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, max_gap(len)));
         end
      end
      if (variant == 1) push_bits($urandom, 24);
      if (variant != 2) begin
         push_bits(1, 1); push_bits(LEN_PAT[15], LEN_BITS[15]); push_bits(8'hFF, 8);
      end
      while (code_bits.size() % 8 != 0) code_bits.push_back(1'b0);
      while (code_bits.size() != 0) begin
         b = 8'h00;
         for (int i = 0; i < 8; i++) b[i] = code_bits.pop_front();
         stream_bytes.push_back(b);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(isd_pkg::KIND_CONT, 8'h00);
      send_item(isd_pkg::KIND_DATA, {7'd0, ascii_mode});
      send_item(isd_pkg::KIND_DATA, 8'(dict_bits));
      foreach (stream_bytes[i]) begin
         calm = (i >= 60 && i < 110);
         if (i == 100) begin
            req_valid <= 1'b0;
            while (expected_left != 0) @(posedge clock);
         end
         if ($urandom_range(0, 99) < 8)
            send_item(($urandom_range(0, 1) == 0) ? KIND_ALIAS_CONT : isd_pkg::KIND_CONT,
                      8'h00);
         drain_then_send(isd_pkg::KIND_DATA, stream_bytes[i]);
      end
      calm = 1'b0;
      drain_then_send(isd_pkg::KIND_END, 8'h00);
      send_item(isd_pkg::KIND_DATA, 8'($urandom));
      send_item(isd_pkg::KIND_CONT, 8'h00);
      send_item(isd_pkg::KIND_END, 8'h00);
      req_valid <= 1'b0;
      while (expected_left != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("stream of %0d bytes (%s mode, %0d dictionary bits), %0d requests sent",
               stream_bytes.size(), ascii_mode ? "ascii" : "binary", dict_bits,
               request_count);
      $display("%0d bytes decompressed, data-while-busy case %0s", bytes_out,
               rejected ? "hit" : "not hit");
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
